@@ design/cda_pkg.sv @@
// ---------------------------------------------------------------------------
// cda_pkg
// types, codes and month table shared by the date arithmetic block
// ---------------------------------------------------------------------------
package cda_pkg;

    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_SUB  = 2'd1;
    localparam logic [1:0] OP_DIFF = 2'd2;
    localparam logic [1:0] OP_CMP  = 2'd3;

    localparam logic [2:0] RES_PASS   = 3'd0;
    localparam logic [2:0] RES_OVF    = 3'd1;
    localparam logic [2:0] RES_DATE   = 3'd2;
    localparam logic [2:0] RES_DIFF   = 3'd3;
    localparam logic [2:0] RES_NODIFF = 3'd4;
    localparam logic [2:0] RES_CMP    = 3'd5;

    localparam logic [3:0] MONTHS     = 4'd12;
    localparam logic [3:0] MONTH_LIM  = 4'd13;

    typedef struct packed {
        logic       load;
        logic       yr_clr;
        logic       acc_clr;
        logic       yr_step;
        logic       mo_clr;
        logic       mo_step;
        logic       sub_mode;
        logic       sel_b;
        logic       cap_a;
        logic       set_t;
        logic       fin;
        logic [2:0] res;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       y_ok;
        logic       m_ok;
        logic       y_hit;
        logic       m_hit;
        logic       d_valid;
        logic       a_valid;
        logic       under;
        logic       y_over;
        logic       y_fit;
        logic       m_fit;
    } t_sts;

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] l;
        case (m) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: l = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                   l = 5'd30;
            4'd2:                                      l = leap ? 5'd29 : 5'd28;
            default:                                   l = 5'd0;
        endcase
        return l;
    endfunction

endpackage

@@ design/calendar_date_arithmetic.sv @@
// ---------------------------------------------------------------------------
// calendar_date_arithmetic
// gregorian add, subtract, difference and compare of dates
//
// port group      direction  handshake
// start, i_*      in         word taken when start and !busy
// o_valid, o_*    out        word shown for one cycle with o_valid
//
// each date is walked year by year up to its year and month by month up to
// its month, and add or subtract then walk the result out of the day count,
// so a word keeps busy high until its walks are done; the result
// strobes in the same cycle that busy falls
// reset is synchronous, active low, and leaves the block idle
// the receiver cannot stall; results are strobed once
// ---------------------------------------------------------------------------
module calendar_date_arithmetic #(
    parameter int MAX_YEAR = 9999
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_operation,
    input  logic [13:0]        i_year_a,
    input  logic [3:0]         i_month_a,
    input  logic [4:0]         i_day_a,
    input  logic [13:0]        i_year_b,
    input  logic [3:0]         i_month_b,
    input  logic [4:0]         i_day_b,
    input  logic [21:0]        i_day_count,
    output logic               o_valid,
    output logic [13:0]        o_year_out,
    output logic [3:0]         o_month_out,
    output logic [4:0]         o_day_out,
    output logic signed [22:0] o_day_difference,
    output logic               o_is_less,
    output logic               o_is_equal,
    output logic               o_a_valid,
    output logic               o_overflow
);
    import cda_pkg::*;

    t_cmd s_cmd;
    t_sts s_sts;

    cda_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (s_sts),
        .o_cmd   (s_cmd)
    );

    cda_dpath #(.MAX_YEAR(MAX_YEAR)) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (s_cmd),
        .o_sts            (s_sts),
        .i_operation      (i_operation),
        .i_year_a         (i_year_a),
        .i_month_a        (i_month_a),
        .i_day_a          (i_day_a),
        .i_year_b         (i_year_b),
        .i_month_b        (i_month_b),
        .i_day_b          (i_day_b),
        .i_day_count      (i_day_count),
        .o_valid          (o_valid),
        .o_year_out       (o_year_out),
        .o_month_out      (o_month_out),
        .o_day_out        (o_day_out),
        .o_day_difference (o_day_difference),
        .o_is_less        (o_is_less),
        .o_is_equal       (o_is_equal),
        .o_a_valid        (o_a_valid),
        .o_overflow       (o_overflow)
    );

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("start not taken");

    a_fin_strobes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.fin |=> o_valid) else $error("result not strobed");

    a_idle_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy)) else $error("result without work");

    a_ovf_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overflow |-> o_a_valid) else $error("overflow on invalid date");

endmodule

@@ design/cda_ctrl.sv @@
// ---------------------------------------------------------------------------
// cda_ctrl
// sequencer: year walk, month walk, dispatch and serial-to-date walk
// ---------------------------------------------------------------------------
module cda_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  cda_pkg::t_sts i_sts,
    output cda_pkg::t_cmd o_cmd
);
    import cda_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHK  = 3'd1;
    localparam logic [2:0] S_WY   = 3'd2;
    localparam logic [2:0] S_WM   = 3'd3;
    localparam logic [2:0] S_DISP = 3'd4;
    localparam logic [2:0] S_FY   = 3'd5;
    localparam logic [2:0] S_FM   = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_selb, n_selb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_selb  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_selb  <= n_selb;
        end
    end

    assign busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_selb  = r_selb;
        o_cmd   = '0;
        o_cmd.sel_b = r_selb;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_selb     = 1'b0;
                    n_state    = S_CHK;
                end
            end
            S_CHK: begin
                o_cmd.yr_clr  = 1'b1;
                o_cmd.acc_clr = 1'b1;
                o_cmd.mo_clr  = 1'b1;
                if (i_sts.y_ok && i_sts.m_ok) begin
                    n_state = S_WY;
                end else begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                    if (r_selb || i_sts.op == OP_DIFF) begin
                        o_cmd.res = RES_NODIFF;
                    end else if (i_sts.op == OP_CMP) begin
                        o_cmd.res = RES_CMP;
                    end else begin
                        o_cmd.res = RES_PASS;
                    end
                end
            end
            S_WY: begin
                if (i_sts.y_hit) begin
                    n_state = S_WM;
                end else begin
                    o_cmd.yr_step = 1'b1;
                end
            end
            S_WM: begin
                if (i_sts.m_hit) begin
                    if (r_selb) begin
                        o_cmd.fin = 1'b1;
                        o_cmd.res = i_sts.d_valid ? RES_DIFF : RES_NODIFF;
                        n_state   = S_IDLE;
                    end else begin
                        o_cmd.cap_a = 1'b1;
                        n_state     = S_DISP;
                    end
                end else begin
                    o_cmd.mo_step = 1'b1;
                end
            end
            S_DISP: begin
                if (i_sts.op == OP_CMP) begin
                    o_cmd.fin = 1'b1;
                    o_cmd.res = RES_CMP;
                    n_state   = S_IDLE;
                end else if (!i_sts.a_valid) begin
                    o_cmd.fin = 1'b1;
                    o_cmd.res = (i_sts.op == OP_DIFF) ? RES_NODIFF : RES_PASS;
                    n_state   = S_IDLE;
                end else if (i_sts.op == OP_DIFF) begin
                    n_selb  = 1'b1;
                    n_state = S_CHK;
                end else if (i_sts.op == OP_SUB && i_sts.under) begin
                    o_cmd.fin = 1'b1;
                    o_cmd.res = RES_OVF;
                    n_state   = S_IDLE;
                end else begin
                    o_cmd.set_t  = 1'b1;
                    o_cmd.yr_clr = 1'b1;
                    o_cmd.mo_clr = 1'b1;
                    n_state      = S_FY;
                end
            end
            S_FY: begin
                o_cmd.sub_mode = 1'b1;
                if (i_sts.y_over) begin
                    o_cmd.fin = 1'b1;
                    o_cmd.res = RES_OVF;
                    n_state   = S_IDLE;
                end else if (i_sts.y_fit) begin
                    o_cmd.yr_step = 1'b1;
                end else begin
                    n_state = S_FM;
                end
            end
            S_FM: begin
                o_cmd.sub_mode = 1'b1;
                if (i_sts.m_fit) begin
                    o_cmd.mo_step = 1'b1;
                end else begin
                    o_cmd.fin = 1'b1;
                    o_cmd.res = RES_DATE;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ design/cda_dpath.sv @@
// ---------------------------------------------------------------------------
// cda_dpath
// operand and result registers, year and month counters, day accumulator
// ---------------------------------------------------------------------------
module cda_dpath #(
    parameter int MAX_YEAR = 9999
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cda_pkg::t_cmd        i_cmd,
    output cda_pkg::t_sts        o_sts,
    input  logic [1:0]           i_operation,
    input  logic [13:0]          i_year_a,
    input  logic [3:0]           i_month_a,
    input  logic [4:0]           i_day_a,
    input  logic [13:0]          i_year_b,
    input  logic [3:0]           i_month_b,
    input  logic [4:0]           i_day_b,
    input  logic [21:0]          i_day_count,
    output logic                 o_valid,
    output logic [13:0]          o_year_out,
    output logic [3:0]           o_month_out,
    output logic [4:0]           o_day_out,
    output logic signed [22:0]   o_day_difference,
    output logic                 o_is_less,
    output logic                 o_is_equal,
    output logic                 o_a_valid,
    output logic                 o_overflow
);
    import cda_pkg::*;

    localparam int YW = $clog2(MAX_YEAR + 2);
    localparam int SW = $clog2((MAX_YEAR + 1) * 366 + 4194304);

    logic [1:0]    r_op;
    logic [13:0]   r_ya, r_yb;
    logic [3:0]    r_ma, r_mb;
    logic [4:0]    r_da, r_db;
    logic [21:0]   r_cnt;
    logic [YW-1:0] r_y;
    logic [1:0]    r_m4;
    logic [6:0]    r_m100;
    logic [8:0]    r_m400;
    logic [3:0]    r_k;
    logic [SW-1:0] r_acc, r_sa;
    logic          r_va;
    logic          r_done;

    logic [13:0]   ty;
    logic [3:0]    tm;
    logic [4:0]    td;
    logic          leap;
    logic [8:0]    ylen;
    logic [4:0]    mlen_k;
    logic [SW-1:0] sb;
    logic          less;

    assign ty     = i_cmd.sel_b ? r_yb : r_ya;
    assign tm     = i_cmd.sel_b ? r_mb : r_ma;
    assign td     = i_cmd.sel_b ? r_db : r_da;
    assign leap   = ((r_m4 == 2'd0) && (r_m100 != 7'd0)) || (r_m400 == 9'd0);
    assign ylen   = leap ? 9'd366 : 9'd365;
    assign mlen_k = month_len(r_k, leap);
    assign sb     = r_acc + SW'(td) - SW'(1);

    always_comb begin
        if (r_ya != r_yb) begin
            less = r_ya < r_yb;
        end else if (r_ma != r_mb) begin
            less = r_ma < r_mb;
        end else begin
            less = r_da < r_db;
        end
    end

    always_comb begin
        o_sts.op      = r_op;
        o_sts.y_ok    = (ty != 14'd0) && (32'(ty) <= MAX_YEAR);
        o_sts.m_ok    = (tm != 4'd0) && (tm <= MONTHS);
        o_sts.y_hit   = (r_y == YW'(ty));
        o_sts.m_hit   = (r_k == tm);
        o_sts.d_valid = (td != 5'd0) && (td <= month_len(tm, leap));
        o_sts.a_valid = r_va;
        o_sts.under   = SW'(r_cnt) > r_sa;
        o_sts.y_over  = (32'(r_y) > MAX_YEAR);
        o_sts.y_fit   = r_acc >= SW'(ylen);
        o_sts.m_fit   = (r_k < MONTHS) && (r_acc >= SW'(mlen_k));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_operation;
            r_ya  <= i_year_a;
            r_ma  <= i_month_a;
            r_da  <= i_day_a;
            r_yb  <= i_year_b;
            r_mb  <= i_month_b;
            r_db  <= i_day_b;
            r_cnt <= i_day_count;
            r_va  <= 1'b0;
        end else if (i_cmd.cap_a) begin
            r_sa <= sb;
            r_va <= o_sts.d_valid;
        end

        if (i_cmd.yr_clr) begin
            r_y    <= YW'(1);
            r_m4   <= 2'd1;
            r_m100 <= 7'd1;
            r_m400 <= 9'd1;
        end else if (i_cmd.yr_step) begin
            r_y    <= r_y + YW'(1);
            r_m4   <= r_m4 + 2'd1;
            r_m100 <= (r_m100 == 7'd99) ? 7'd0 : r_m100 + 7'd1;
            r_m400 <= (r_m400 == 9'd399) ? 9'd0 : r_m400 + 9'd1;
        end

        if (i_cmd.mo_clr) begin
            r_k <= 4'd1;
        end else if (i_cmd.mo_step && r_k < MONTH_LIM) begin
            r_k <= r_k + 4'd1;
        end

        if (i_cmd.set_t) begin
            r_acc <= (r_op == OP_ADD) ? r_sa + SW'(r_cnt) : r_sa - SW'(r_cnt);
        end else if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (i_cmd.yr_step) begin
            r_acc <= i_cmd.sub_mode ? r_acc - SW'(ylen) : r_acc + SW'(ylen);
        end else if (i_cmd.mo_step) begin
            r_acc <= i_cmd.sub_mode ? r_acc - SW'(mlen_k) : r_acc + SW'(mlen_k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            o_year_out       <= 14'd0;
            o_month_out      <= 4'd0;
            o_day_out        <= 5'd0;
            o_day_difference <= '0;
            o_is_less        <= 1'b0;
            o_is_equal       <= 1'b0;
            o_overflow       <= 1'b0;
            o_a_valid        <= r_va;
            case (i_cmd.res) inside
                RES_PASS, RES_OVF: begin
                    o_year_out  <= r_ya;
                    o_month_out <= r_ma;
                    o_day_out   <= r_da;
                    o_overflow  <= (i_cmd.res == RES_OVF);
                end
                RES_DATE: begin
                    o_year_out  <= 14'(r_y);
                    o_month_out <= r_k;
                    o_day_out   <= 5'(r_acc + SW'(1));
                end
                RES_DIFF: begin
                    o_day_difference <= 23'(r_sa - sb);
                end
                RES_CMP: begin
                    o_is_less  <= less;
                    o_is_equal <= (r_ya == r_yb) && (r_ma == r_mb) && (r_da == r_db);
                end
                default: begin
                end
            endcase
        end
    end

    assign o_valid = r_done;

endmodule
